/* rtl/dps_pkg.sv */
// Package with the shared types, sizes and pattern table of the dangerous pattern scanner.
`timescale 1ns / 1ps
`default_nettype none

package dps_pkg;

    // Sizes of the byte history and the pattern set.
    localparam int HIST_DEPTH   = 16;
    localparam int NUM_PAT      = 12;
    localparam int IDX_W        = 4;
    localparam int BYTES_W      = 12;
    localparam int LEN_W        = 5;
    localparam int WINDOW_BYTES = 4096;

    // History of bytes; entry 0 is the newest byte.
    typedef logic [HIST_DEPTH-1:0][7:0] t_hist;

    // Pattern text, right-justified, so that byte 0 is the last character.
    // The leading 'i' of "import subprocess" does not fit the history and is dropped.
    localparam t_hist PAT_TEXT [NUM_PAT] = '{
        t_hist'("exec("),
        t_hist'("eval("),
        t_hist'("compile("),
        t_hist'("__reduce__"),
        t_hist'("__reduce\137ex__"),
        t_hist'("subprocess"),
        t_hist'("pty.spawn"),
        t_hist'("os.system"),
        t_hist'("import os"),
        t_hist'("mport subprocess"),
        t_hist'("pickle.loads"),
        t_hist'("marshal.loads")
    };

    // Number of history bytes compared for each pattern.
    localparam logic [LEN_W-1:0] PAT_LEN [NUM_PAT] = '{
        5'd5, 5'd5, 5'd8, 5'd10, 5'd13, 5'd10,
        5'd9, 5'd9, 5'd9, 5'd16, 5'd12, 5'd13
    };

endpackage

`default_nettype wire

/* rtl/dps_if.sv */
// Valid/ready channel interfaces for the input bytes and the scan results.
`timescale 1ns / 1ps
`default_nettype none

interface dps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface dps_out_if;
    logic        valid;
    logic        ready;
    logic        safe;
    logic [3:0]  pattern_index;
    logic [11:0] bytes_scanned;

    modport source (output valid, output safe, output pattern_index, output bytes_scanned,
                    input ready);
    modport sink (input valid, input safe, input pattern_index, input bytes_scanned,
                  output ready);
endinterface

`default_nettype wire

/* rtl/dps_matcher.sv */
// Parallel comparison of the byte history against all dangerous patterns.
`timescale 1ns / 1ps
`default_nettype none

module dps_matcher
    import dps_pkg::*;
(
    input  wire t_hist              i_hist,
    output logic [NUM_PAT-1:0]      o_hit
);

    // Each pattern matches when its last bytes equal the newest history bytes.
    always_comb begin
        for (int p = 0; p < NUM_PAT; p++) begin
            o_hit[p] = 1'b1;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                if ((LEN_W'(i) < PAT_LEN[p]) && (i_hist[i] != PAT_TEXT[p][i])) begin
                    o_hit[p] = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/dangerous_pattern_scanner_unit.sv */
// Top level of the dangerous pattern scanner: history, found mask and result register.
// Throughput: one byte transaction per cycle; input stalls only while a result is held off.
// The result is registered and appears in the cycle after the end-of-data byte is accepted.
// The pattern compare runs in parallel on the updated history in the same cycle.
// Reset (synchronous, active low) clears the history, found mask, count and output valid.
// After each result the scan state returns to its reset value for the next header.
`timescale 1ns / 1ps
`default_nettype none

module dangerous_pattern_scanner_unit
    import dps_pkg::*;
#(
    parameter int WINDOW_BYTES = dps_pkg::WINDOW_BYTES
)(
    input  wire        i_clk,
    input  wire        i_rst_n,
    dps_in_if.sink     i_in,
    dps_out_if.source  o_out
);

    localparam int CNT_W = $clog2(WINDOW_BYTES);
    localparam int EXT_W = CNT_W + BYTES_W;

    // Lowest index set in the found mask.
    function automatic logic [IDX_W-1:0] lowest_index(input logic [NUM_PAT-1:0] mask);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int p = NUM_PAT - 1; p >= 0; p--) begin
            if (mask[p]) begin
                idx = IDX_W'(p);
            end
        end
        return idx;
    endfunction

    t_hist              r_hist;
    t_hist              n_hist;
    logic [NUM_PAT-1:0] r_found;
    logic [NUM_PAT-1:0] n_found;
    logic [NUM_PAT-1:0] hit;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_zero_seen;
    logic               n_zero_seen;
    logic               r_out_valid;
    logic               r_safe;
    logic [IDX_W-1:0]   r_idx;
    logic [BYTES_W-1:0] r_bytes;
    logic [EXT_W-1:0]   count_ext;
    logic [BYTES_W-1:0] bytes_sat;
    logic               in_acc;
    logic               active;
    logic               take;

    // Input is taken whenever the result register is free or drains this cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    // A byte is examined only before the first zero byte and inside the window.
    assign active = !r_zero_seen && (r_count < CNT_W'(WINDOW_BYTES - 1));
    assign take   = active && (i_in.data_byte != 8'd0);

    // Next scan state for the byte in this transaction.
    always_comb begin
        n_hist      = take ? {r_hist[HIST_DEPTH-2:0], i_in.data_byte} : r_hist;
        n_count     = take ? r_count + CNT_W'(1) : r_count;
        n_zero_seen = r_zero_seen || (active && (i_in.data_byte == 8'd0));
        n_found     = r_found | (take ? hit : '0);
    end

    dps_matcher u_matcher (
        .i_hist (n_hist),
        .o_hit  (hit)
    );

    // Reported byte count saturates at the width of the result field.
    assign count_ext = EXT_W'(n_count);
    assign bytes_sat = (count_ext > EXT_W'({BYTES_W{1'b1}})) ? {BYTES_W{1'b1}}
                                                            : count_ext[BYTES_W-1:0];

    // Scan state update; end of data returns the state to its reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '0;
            r_found     <= '0;
            r_count     <= '0;
            r_zero_seen <= 1'b0;
        end else if (in_acc) begin
            if (i_in.end_of_data) begin
                r_hist      <= '0;
                r_found     <= '0;
                r_count     <= '0;
                r_zero_seen <= 1'b0;
            end else begin
                r_hist      <= n_hist;
                r_found     <= n_found;
                r_count     <= n_count;
                r_zero_seen <= n_zero_seen;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_in.end_of_data) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, loaded on the end-of-data byte.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.end_of_data) begin
            r_safe  <= (n_found == '0);
            r_idx   <= lowest_index(n_found);
            r_bytes <= bytes_sat;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.safe          = r_safe;
    assign o_out.pattern_index = r_idx;
    assign o_out.bytes_scanned = r_bytes;

endmodule

`default_nettype wire
